// File: hw/rtl/ttce_pkg.sv
// ----------------------------------------------------------------------------
// ttce_pkg
// Shared types and codes of the text terminal command engine: the decoded
// operation handed from the front end to the back end, byte codes and states.
// ----------------------------------------------------------------------------
package ttce_pkg;

	// register offsets of the configuration port
	localparam logic [2:0] REG_CLEAR_CHAR = 3'd0;

	// terminal byte codes
	localparam logic [7:0] CH_AS_ON    = 8'd4;
	localparam logic [7:0] CH_AS_OFF   = 8'd5;
	localparam logic [7:0] CH_LEFT     = 8'd8;
	localparam logic [7:0] CH_RIGHT    = 8'd9;
	localparam logic [7:0] CH_DOWN     = 8'd10;
	localparam logic [7:0] CH_UP       = 8'd11;
	localparam logic [7:0] CH_CLEAR    = 8'd12;
	localparam logic [7:0] CH_CR       = 8'd13;
	localparam logic [7:0] CH_VDU23    = 8'd23;
	localparam logic [7:0] CH_FULL     = 8'd26;
	localparam logic [7:0] CH_LITERAL  = 8'd27;
	localparam logic [7:0] CH_VIEWPORT = 8'd28;
	localparam logic [7:0] CH_HOME     = 8'd30;
	localparam logic [7:0] CH_MOVE     = 8'd31;
	localparam logic [7:0] CH_PRINT_LO = 8'd32;
	localparam logic [7:0] CH_DELETE   = 8'd127;

	// parameter counts of the multi-byte commands
	localparam logic [3:0] NPAR_VDU23    = 4'd9;
	localparam logic [3:0] NPAR_LITERAL  = 4'd1;
	localparam logic [3:0] NPAR_VIEWPORT = 4'd4;
	localparam logic [3:0] NPAR_MOVE     = 4'd2;

	// selectors of command 23
	localparam logic [7:0] SEL_CURSOR = 8'd1;
	localparam logic [7:0] SEL_SCROLL = 8'd7;
	localparam logic [7:0] NUM_DIRS   = 8'd4;

	// input opcodes
	localparam logic OPC_FEED = 1'b0;
	localparam logic OPC_READ = 1'b1;

	typedef enum logic [1:0] {
		CMD_VDU23    = 2'd0,
		CMD_LITERAL  = 2'd1,
		CMD_VIEWPORT = 2'd2,
		CMD_MOVE     = 2'd3
	} pend_cmd_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_READ, OP_AS_ON, OP_AS_OFF, OP_LEFT, OP_RIGHT, OP_DOWN, OP_UP,
		OP_CLEAR, OP_CR, OP_FULL, OP_HOME, OP_PUT, OP_DEL, OP_CUR_EN, OP_SCROLL,
		OP_VIEW, OP_MOVE
	} op_kind_t;

	// decoded operation; meaning of p0..p3 depends on kind
	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  p0;       // char, flag, direction, left or column
		logic [7:0]  p1;       // whole-screen flag, bottom or row
		logic [7:0]  p2;       // right
		logic [7:0]  p3;       // top
		logic [3:0]  rd_row;
		logic [4:0]  rd_col;
		logic [3:0]  pend;     // parameter bytes still awaited
	} op_t;

	// status from back end to front end
	typedef struct packed {
		logic init_done;
	} back_stat_t;

	// scan modes, direction codes match command 23
	typedef enum logic [2:0] {
		SC_RIGHT = 3'd0,
		SC_LEFT  = 3'd1,
		SC_DOWN  = 3'd2,
		SC_UP    = 3'd3,
		SC_CLEAR = 3'd4
	} scan_mode_t;

	typedef enum logic [3:0] {
		B_INIT, B_IDLE, B_DO, B_RDW, B_RIGHT, B_LEFT, B_DOWN, B_UP,
		B_SCRD, B_SCWR, B_DELWR, B_OUT
	} back_state_t;

endpackage

// File: hw/rtl/ttce_if.sv
// ----------------------------------------------------------------------------
// ttce_if
// Valid/ready channels of the engine: command items in, result items out.
// ----------------------------------------------------------------------------
interface ttce_cmd_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] data_byte;
	logic [3:0] cell_row;
	logic [4:0] cell_column;

	modport source (output valid, opcode, data_byte, cell_row, cell_column, input ready);
	modport sink   (input valid, opcode, data_byte, cell_row, cell_column, output ready);
endinterface

interface ttce_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [3:0] cursor_row_out;
	logic [4:0] cursor_column_out;
	logic       cursor_on;
	logic       autoscroll_on;
	logic [3:0] params_pending;

	modport source (output valid, read_data, cursor_row_out, cursor_column_out, cursor_on,
		autoscroll_on, params_pending, input ready);
	modport sink   (input valid, read_data, cursor_row_out, cursor_column_out, cursor_on,
		autoscroll_on, params_pending, output ready);
endinterface

// File: hw/rtl/text_terminal_command_engine_core.sv
// ----------------------------------------------------------------------------
// text_terminal_command_engine_core
// Sequencing: the back end takes one item at a time; a line wrap or a delete
//   adds a step, a clear sweeps every viewport cell and a scroll copies each
//   moved cell and fills the vacated edge; the two-entry queue lets the front
//   end accept meanwhile.
// Reset: after arst_n the buffer is cleared over ROWS*COLUMNS cycles, during
//   which no item is accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module text_terminal_command_engine_core #(
	parameter int COLUMNS = 32,
	parameter int ROWS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ttce_cmd_if.sink    cmd,
	ttce_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ttce_pkg::*;

	logic       clear_q;
	logic [7:0] clear_char_q;
	logic       q_push, q_can_push, q_pop, q_head_valid;
	op_t        q_in_op, q_head_op;
	back_stat_t stat;

	// configuration register
	assign pready  = 1'b1;
	assign clear_q = psel && penable && pwrite && pready && paddr == REG_CLEAR_CHAR;
	assign prdata  = (paddr == REG_CLEAR_CHAR) ? {24'd0, clear_char_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_char_q <= 8'd32;
		end else if (clear_q) begin
			clear_char_q <= pwdata[7:0];
		end
	end

	ttce_front u_front (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.q_can_push(q_can_push), .q_push(q_push), .q_op(q_in_op)
	);

	ttce_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_op(q_in_op),
		.can_push(q_can_push), .pop(q_pop), .head_valid(q_head_valid), .head_op(q_head_op)
	);

	ttce_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
		.clk(clk), .arst_n(arst_n), .clear_char(clear_char_q),
		.head_valid(q_head_valid), .head_op(q_head_op), .pop(q_pop), .stat(stat), .rsp(rsp)
	);

`ifndef SYNTHESIS
	a_no_accept_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |-> stat.init_done)
		else $error("item accepted during buffer clearing");
	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.params_pending <= 4'd9)
		else $error("parameter count out of range");
	a_cursor_row: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> int'(rsp.cursor_row_out) < ROWS)
		else $error("cursor row outside screen");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head_valid)
		else $error("queue popped while empty");
`endif
endmodule

// File: hw/rtl/ttce_ram.sv
// ----------------------------------------------------------------------------
// ttce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hw/rtl/ttce_front.sv
// ----------------------------------------------------------------------------
// ttce_front
// Front end: accept command items, collect parameter bytes and classify each
// item into one decoded operation for the back end.
// ----------------------------------------------------------------------------
module ttce_front (
	input  logic                clk,
	input  logic                arst_n,
	ttce_cmd_if.sink            cmd,
	input  ttce_pkg::back_stat_t stat,
	input  logic                q_can_push,
	output logic                q_push,
	output ttce_pkg::op_t       q_op
);
	import ttce_pkg::*;

	logic [3:0] pcnt_q;
	pend_cmd_t  pcmd_q;
	logic [7:0] store_q [9];

	logic [3:0] pcnt_d;
	pend_cmd_t  pcmd_d;
	op_t        op;
	logic [7:0] c;

	assign cmd.ready = q_can_push & stat.init_done;
	assign q_push    = cmd.valid & cmd.ready;
	assign c         = cmd.data_byte;
	assign q_op      = op;

	// classify the item
	always_comb begin
		pcnt_d    = pcnt_q;
		pcmd_d    = pcmd_q;
		op        = '0;
		op.kind   = OP_NOP;
		op.rd_row = cmd.cell_row;
		op.rd_col = cmd.cell_column;
		if (cmd.opcode == OPC_READ) begin
			op.kind = OP_READ;
		end else if (pcnt_q != 4'd0) begin
			pcnt_d = pcnt_q - 4'd1;
			if (pcnt_q == 4'd1) begin
				unique case (pcmd_q)
					CMD_VDU23: begin
						if (store_q[8] == SEL_CURSOR) begin
							op.kind = OP_CUR_EN;
							op.p0   = {7'd0, store_q[7] != 8'd0};
						end else if (store_q[8] == SEL_SCROLL && store_q[6] < NUM_DIRS) begin
							op.kind = OP_SCROLL;
							op.p0   = store_q[6];
							op.p1   = {7'd0, store_q[7] != 8'd0};
						end
					end
					CMD_LITERAL: begin
						op.kind = OP_PUT;
						op.p0   = c;
					end
					CMD_VIEWPORT: begin
						op.kind = OP_VIEW;
						op.p0   = store_q[3];
						op.p1   = store_q[2];
						op.p2   = store_q[1];
						op.p3   = c;
					end
					CMD_MOVE: begin
						op.kind = OP_MOVE;
						op.p0   = store_q[1];
						op.p1   = c;
					end
				endcase
			end
		end else if (c[7]) begin
			op.kind = OP_NOP;
		end else if (c < CH_PRINT_LO) begin
			unique case (c)
				CH_AS_ON:    op.kind = OP_AS_ON;
				CH_AS_OFF:   op.kind = OP_AS_OFF;
				CH_LEFT:     op.kind = OP_LEFT;
				CH_RIGHT:    op.kind = OP_RIGHT;
				CH_DOWN:     op.kind = OP_DOWN;
				CH_UP:       op.kind = OP_UP;
				CH_CLEAR:    op.kind = OP_CLEAR;
				CH_CR:       op.kind = OP_CR;
				CH_FULL:     op.kind = OP_FULL;
				CH_HOME:     op.kind = OP_HOME;
				CH_VDU23:    begin pcmd_d = CMD_VDU23;    pcnt_d = NPAR_VDU23;    end
				CH_LITERAL:  begin pcmd_d = CMD_LITERAL;  pcnt_d = NPAR_LITERAL;  end
				CH_VIEWPORT: begin pcmd_d = CMD_VIEWPORT; pcnt_d = NPAR_VIEWPORT; end
				CH_MOVE:     begin pcmd_d = CMD_MOVE;     pcnt_d = NPAR_MOVE;     end
				default:     op.kind = OP_NOP;
			endcase
		end else if (c == CH_DELETE) begin
			op.kind = OP_DEL;
		end else begin
			op.kind = OP_PUT;
			op.p0   = c;
		end
		op.pend = pcnt_d;
	end

	// hold command collection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= 4'd0;
			pcmd_q <= CMD_VDU23;
		end else if (q_push) begin
			pcnt_q <= pcnt_d;
			pcmd_q <= pcmd_d;
		end
	end

	// store parameter bytes, last one arrives at entry zero
	always_ff @(posedge clk) begin
		if (q_push && cmd.opcode == OPC_FEED && pcnt_q != 4'd0) begin
			store_q[4'(pcnt_q - 4'd1)] <= c;
		end
	end
endmodule

// File: hw/rtl/ttce_queue.sv
// ----------------------------------------------------------------------------
// ttce_queue
// Two-entry queue of decoded operations between front and back end.
// ----------------------------------------------------------------------------
module ttce_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ttce_pkg::op_t push_op,
	output logic          can_push,
	input  logic          pop,
	output logic          head_valid,
	output ttce_pkg::op_t head_op
);
	import ttce_pkg::*;

	op_t        ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign can_push   = cnt_q != 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head_op    = ent_q[rp_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_op;
		end
	end
endmodule

// File: hw/rtl/ttce_back.sv
// ----------------------------------------------------------------------------
// ttce_back
// Back end: carry out decoded operations on cursor, viewport and character
// buffer; sweep the buffer for clears and scrolls; register each result.
// ----------------------------------------------------------------------------
module ttce_back #(
	parameter int COLUMNS = 32,
	parameter int ROWS    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           clear_char,
	input  logic                 head_valid,
	input  ttce_pkg::op_t        head_op,
	output logic                 pop,
	output ttce_pkg::back_stat_t stat,
	ttce_rsp_if.source           rsp
);
	import ttce_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int AW    = $clog2(CELLS);
	localparam logic [RW-1:0] ROW_MAX = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_MAX = CW'(COLUMNS - 1);
	localparam logic [AW-1:0] ADDR_MAX = AW'(CELLS - 1);

	function automatic logic [AW-1:0] cell_addr(input int r, input int k);
		return AW'(r * COLUMNS + k);
	endfunction

	function automatic int clamp_b(input logic [7:0] b, input int hi);
		int v;
		v = b[7] ? 0 : int'(b);
		return (v > hi) ? hi : v;
	endfunction

	back_state_t state_q, state_d;
	op_t         op_q;
	logic [RW-1:0] row_q, vt_q, vb_q;
	logic [CW-1:0] col_q, vl_q, vr_q;
	logic          as_q, ce_q, del_q, oob_q;
	logic [AW-1:0] clr_q;
	logic [7:0]    rd_q;

	// scan engine registers
	scan_mode_t    sm_q;
	logic [RW-1:0] st_q, sb_q, sr_q;
	logic [CW-1:0] sl_q, srt_q, sc_q;

	// result register
	logic       ov_q;
	logic [7:0] o_rd_q;
	logic [3:0] o_row_q, o_pend_q;
	logic [4:0] o_col_q;
	logic       o_ce_q, o_as_q;

	// ram ports
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;

	// launch of a scan
	logic          l_go;
	scan_mode_t    l_mode;
	logic [RW-1:0] l_t, l_b;
	logic [CW-1:0] l_l, l_r;

	// viewport command values
	logic [CW-1:0] nv_l, nv_r;
	logic [RW-1:0] nv_t, nv_b;
	logic          nv_home;
	logic          mv_col, mv_row, rd_in;

	logic          at_right, at_left, at_bot, at_top, out_free, finish_del;
	logic [CW-1:0] c_end, c_start, sc_nx, src_c;
	logic [RW-1:0] r_end, sr_nx, src_r;
	logic          s_fill, s_last;

	ttce_ram #(.WIDTH(8), .DEPTH(CELLS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign stat.init_done = state_q != B_INIT;
	assign out_free   = !ov_q || rsp.ready;
	assign at_right   = col_q >= vr_q;
	assign at_left    = col_q <= vl_q;
	assign at_bot     = row_q >= vb_q;
	assign at_top     = row_q <= vt_q;
	assign finish_del = del_q;
	assign pop        = state_q == B_IDLE && head_valid;

	// scan geometry
	always_comb begin
		c_end   = (sm_q == SC_RIGHT) ? sl_q : srt_q;
		c_start = (sm_q == SC_RIGHT) ? srt_q : sl_q;
		r_end   = (sm_q == SC_DOWN) ? st_q : sb_q;
		s_last  = sc_q == c_end && sr_q == r_end;
		sc_nx   = c_start;
		sr_nx   = sr_q;
		if (sc_q != c_end) begin
			sc_nx = (sm_q == SC_RIGHT) ? sc_q - CW'(1) : sc_q + CW'(1);
		end else begin
			sr_nx = (sm_q == SC_DOWN) ? sr_q - RW'(1) : sr_q + RW'(1);
		end
		unique case (sm_q)
			SC_UP:    s_fill = sr_q == sb_q;
			SC_DOWN:  s_fill = sr_q == st_q;
			SC_RIGHT: s_fill = sc_q == sl_q;
			SC_LEFT:  s_fill = sc_q == srt_q;
			default:  s_fill = 1'b1;
		endcase
		src_r = sr_q;
		src_c = sc_q;
		unique case (sm_q)
			SC_UP:    src_r = sr_q + RW'(1);
			SC_DOWN:  src_r = sr_q - RW'(1);
			SC_RIGHT: src_c = sc_q - CW'(1);
			SC_LEFT:  src_c = sc_q + CW'(1);
			default:  src_r = sr_q;
		endcase
	end

	// viewport clamp, sort and cursor check; move and read range checks
	always_comb begin
		int l, r, t, b;
		l = clamp_b(op_q.p0, COLUMNS - 1);
		b = clamp_b(op_q.p1, ROWS - 1);
		r = clamp_b(op_q.p2, COLUMNS - 1);
		t = clamp_b(op_q.p3, ROWS - 1);
		nv_l = CW'((l > r) ? r : l);
		nv_r = CW'((l > r) ? l : r);
		nv_t = RW'((t > b) ? b : t);
		nv_b = RW'((t > b) ? t : b);
		nv_home = col_q < nv_l || col_q > nv_r || row_q < nv_t || row_q > nv_b;
		mv_col = int'(op_q.p0) >= int'(vl_q) && int'(op_q.p0) <= int'(vr_q);
		mv_row = int'(op_q.p1) >= int'(vt_q) && int'(op_q.p1) <= int'(vb_q);
		rd_in  = int'(op_q.rd_row) < ROWS && int'(op_q.rd_col) < COLUMNS;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_INIT: if (clr_q == ADDR_MAX) state_d = B_IDLE;
			B_IDLE: if (head_valid) state_d = B_DO;
			B_DO: begin
				unique case (op_q.kind)
					OP_READ:            state_d = B_RDW;
					OP_PUT, OP_RIGHT:   state_d = B_RIGHT;
					OP_DEL, OP_LEFT:    state_d = B_LEFT;
					OP_DOWN:            state_d = B_DOWN;
					OP_UP:              state_d = B_UP;
					OP_CLEAR, OP_SCROLL: state_d = B_SCRD;
					default:            state_d = B_OUT;
				endcase
			end
			B_RDW: state_d = B_OUT;
			B_RIGHT: begin
				if (at_right) state_d = B_DOWN;
				else state_d = finish_del ? B_DELWR : B_OUT;
			end
			B_LEFT: begin
				if (at_left) state_d = B_UP;
				else state_d = finish_del ? B_DELWR : B_OUT;
			end
			B_DOWN: begin
				if (at_bot && as_q) state_d = B_SCRD;
				else state_d = finish_del ? B_DELWR : B_OUT;
			end
			B_UP: begin
				if (at_top && as_q) state_d = B_SCRD;
				else state_d = finish_del ? B_DELWR : B_OUT;
			end
			B_SCRD: begin
				if (!s_fill) state_d = B_SCWR;
				else if (s_last) state_d = finish_del ? B_DELWR : B_OUT;
			end
			B_SCWR: begin
				if (s_last) state_d = finish_del ? B_DELWR : B_OUT;
				else state_d = B_SCRD;
			end
			B_DELWR: state_d = B_OUT;
			B_OUT: if (out_free) state_d = B_IDLE;
			default: state_d = B_INIT;
		endcase
	end

	// ram controls and scan launch
	always_comb begin
		we     = 1'b0;
		waddr  = cell_addr(int'(row_q), int'(col_q));
		wdata  = clear_char;
		raddr  = cell_addr(int'(src_r), int'(src_c));
		l_go   = 1'b0;
		l_mode = SC_CLEAR;
		l_l    = vl_q;
		l_r    = vr_q;
		l_t    = vt_q;
		l_b    = vb_q;
		unique case (state_q)
			B_INIT: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = 8'd0;
			end
			B_DO: begin
				if (op_q.kind == OP_READ) begin
					raddr = rd_in ? cell_addr(int'(op_q.rd_row), int'(op_q.rd_col)) : '0;
				end
				if (op_q.kind == OP_PUT) begin
					we    = 1'b1;
					wdata = op_q.p0;
				end
				if (op_q.kind == OP_CLEAR) begin
					l_go = 1'b1;
				end
				if (op_q.kind == OP_SCROLL) begin
					l_go   = 1'b1;
					l_mode = scan_mode_t'({1'b0, op_q.p0[1:0]});
					if (op_q.p1[0]) begin
						l_l = '0;
						l_r = COL_MAX;
						l_t = '0;
						l_b = ROW_MAX;
					end
				end
			end
			B_DOWN: begin
				l_go   = at_bot && as_q;
				l_mode = SC_UP;
			end
			B_UP: begin
				l_go   = at_top && as_q;
				l_mode = SC_DOWN;
			end
			B_SCRD: begin
				we    = s_fill;
				waddr = cell_addr(int'(sr_q), int'(sc_q));
			end
			B_SCWR: begin
				we    = 1'b1;
				waddr = cell_addr(int'(sr_q), int'(sc_q));
				wdata = rdata;
			end
			B_DELWR: we = 1'b1;
			default: we = 1'b0;
		endcase
	end

	// control and cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			clr_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			vl_q    <= '0;
			vr_q    <= COL_MAX;
			vt_q    <= '0;
			vb_q    <= ROW_MAX;
			as_q    <= 1'b1;
			ce_q    <= 1'b1;
			del_q   <= 1'b0;
			oob_q   <= 1'b0;
			ov_q    <= 1'b0;
			sm_q    <= SC_CLEAR;
			sl_q    <= '0;
			srt_q   <= '0;
			st_q    <= '0;
			sb_q    <= '0;
			sr_q    <= '0;
			sc_q    <= '0;
		end else begin
			state_q <= state_d;
			// raise on a result, drop once it is taken
			ov_q <= (state_q == B_OUT && out_free) || (ov_q && !rsp.ready);
			unique case (state_q)
				B_INIT: clr_q <= clr_q + AW'(1);
				B_IDLE: del_q <= 1'b0;
				B_DO: begin
					unique case (op_q.kind)
						OP_AS_ON:  as_q <= 1'b1;
						OP_AS_OFF: as_q <= 1'b0;
						OP_CUR_EN: ce_q <= op_q.p0[0];
						OP_CR:     col_q <= vl_q;
						OP_DEL:    del_q <= 1'b1;
						OP_HOME, OP_CLEAR: begin
							row_q <= vt_q;
							col_q <= vl_q;
						end
						OP_FULL: begin
							vl_q  <= '0;
							vr_q  <= COL_MAX;
							vt_q  <= '0;
							vb_q  <= ROW_MAX;
							row_q <= '0;
							col_q <= '0;
						end
						OP_VIEW: begin
							vl_q <= nv_l;
							vr_q <= nv_r;
							vt_q <= nv_t;
							vb_q <= nv_b;
							if (nv_home) begin
								row_q <= nv_t;
								col_q <= nv_l;
							end
						end
						OP_MOVE: begin
							if (mv_col) col_q <= CW'(op_q.p0);
							if (mv_row) row_q <= RW'(op_q.p1);
						end
						default: oob_q <= !rd_in;
					endcase
				end
				B_RIGHT: col_q <= at_right ? vl_q : col_q + CW'(1);
				B_LEFT:  col_q <= at_left ? vr_q : col_q - CW'(1);
				B_DOWN: begin
					if (!at_bot) row_q <= row_q + RW'(1);
					else if (!as_q) row_q <= vt_q;
				end
				B_UP: begin
					if (!at_top) row_q <= row_q - RW'(1);
					else if (!as_q) row_q <= vb_q;
				end
				B_SCRD: begin
					if (s_fill) begin
						sr_q <= sr_nx;
						sc_q <= sc_nx;
					end
				end
				B_SCWR: begin
					sr_q <= sr_nx;
					sc_q <= sc_nx;
				end
				default: ;
			endcase
			if (l_go) begin
				sm_q  <= l_mode;
				sl_q  <= l_l;
				srt_q <= l_r;
				st_q  <= l_t;
				sb_q  <= l_b;
				sr_q  <= (l_mode == SC_DOWN) ? l_b : l_t;
				sc_q  <= (l_mode == SC_RIGHT) ? l_r : l_l;
			end
		end
	end

	// operation, read data and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head_op;
		end
		if (state_q == B_RDW) begin
			rd_q <= oob_q ? 8'd0 : rdata;
		end
		if (state_q == B_OUT && out_free) begin
			o_rd_q   <= (op_q.kind == OP_READ) ? rd_q : 8'd0;
			o_row_q  <= 4'(row_q);
			o_col_q  <= 5'(col_q);
			o_ce_q   <= ce_q;
			o_as_q   <= as_q;
			o_pend_q <= op_q.pend;
		end
	end

	assign rsp.valid             = ov_q;
	assign rsp.read_data         = o_rd_q;
	assign rsp.cursor_row_out    = o_row_q;
	assign rsp.cursor_column_out = o_col_q;
	assign rsp.cursor_on         = o_ce_q;
	assign rsp.autoscroll_on     = o_as_q;
	assign rsp.params_pending    = o_pend_q;
endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_terminal_command_engine_core. Feeds terminal
// byte streams and cell reads through the command channel, predicts the
// cursor, flags and cell contents of every transfer, and compares each
// result transfer with the oldest prediction. Exercises the fill character
// register across several phases.
// ----------------------------------------------------------------------------
module tb;
	import ttce_pkg::*;

	localparam int NCOL     = 32;
	localparam int NROW     = 16;
	localparam int N_ITEMS  = 1650;
	localparam int WDOG_MAX = 20000;

	typedef struct {
		logic [7:0] rd;
		logic [3:0] row;
		logic [4:0] col;
		logic       cur_en;
		logic       as_en;
		logic [3:0] pend;
	} term_status_t;

	// terminal predictor and store of expected status transfers
	class term_scoreboard;
		logic [7:0]   screen [0:NROW*NCOL-1];
		int           row, col, vl, vr, vt, vb;
		bit           as_f, ce_f;
		logic [7:0]   prm [0:8];
		int           pcnt;
		pend_cmd_t    pcmd;
		logic [7:0]   fill;
		term_status_t expected_status [$];
		bit           failed;

		function new();
			foreach (screen[i]) screen[i] = 8'd0;
			foreach (prm[i]) prm[i] = 8'd0;
			row = 0; col = 0; vl = 0; vr = NCOL-1; vt = 0; vb = NROW-1;
			as_f = 1; ce_f = 1; pcnt = 0; pcmd = CMD_VDU23; fill = 8'd32; failed = 0;
		endfunction

		function void put(int r, int c, logic [7:0] v);
			if (r >= 0 && r < NROW && c >= 0 && c < NCOL) screen[r*NCOL+c] = v;
		endfunction

		function logic [7:0] get(int r, int c);
			if (r >= 0 && r < NROW && c >= 0 && c < NCOL) return screen[r*NCOL+c];
			return 8'd0;
		endfunction

		// shift the viewport contents one cell, fill the vacated edge
		function void shift_view(logic [7:0] dir);
			case (dir)
				8'(SC_RIGHT): for (int r = vt; r <= vb; r++) begin
					for (int c = vr; c > vl; c--) put(r, c, get(r, c-1));
					put(r, vl, fill);
				end
				8'(SC_LEFT): for (int r = vt; r <= vb; r++) begin
					for (int c = vl; c < vr; c++) put(r, c, get(r, c+1));
					put(r, vr, fill);
				end
				8'(SC_DOWN): begin
					for (int r = vb; r > vt; r--)
						for (int c = vl; c <= vr; c++) put(r, c, get(r-1, c));
					for (int c = vl; c <= vr; c++) put(vt, c, fill);
				end
				8'(SC_UP): begin
					for (int r = vt; r < vb; r++)
						for (int c = vl; c <= vr; c++) put(r, c, get(r+1, c));
					for (int c = vl; c <= vr; c++) put(vb, c, fill);
				end
				default: ;
			endcase
		endfunction

		function void go_down();
			if (++row > vb) begin
				if (as_f) begin shift_view(8'(SC_UP)); row = vb; end
				else row = vt;
			end
		endfunction

		function void go_up();
			if (--row < vt) begin
				if (as_f) begin shift_view(8'(SC_DOWN)); row = vt; end
				else row = vb;
			end
		endfunction

		function void go_right();
			if (++col > vr) begin col = vl; go_down(); end
		endfunction

		function void go_left();
			if (--col < vl) begin col = vr; go_up(); end
		endfunction

		function int clamp(logic [7:0] b, int hi);
			int v;
			v = b[7] ? 0 : int'(b);
			return v > hi ? hi : v;
		endfunction

		// complete a parameterised command
		function void run_cmd();
			int l, r, t, b, s;
			case (pcmd)
				CMD_VDU23: begin
					if (prm[8] == SEL_CURSOR) ce_f = (prm[7] != 0);
					else if (prm[8] == SEL_SCROLL) begin
						l = vl; r = vr; t = vt; b = vb;
						if (prm[7] != 0) begin vl = 0; vr = NCOL-1; vt = 0; vb = NROW-1; end
						shift_view(prm[6]);
						vl = l; vr = r; vt = t; vb = b;
					end
				end
				CMD_LITERAL: begin put(row, col, prm[0]); go_right(); end
				CMD_VIEWPORT: begin
					l = clamp(prm[3], NCOL-1); r = clamp(prm[1], NCOL-1);
					b = clamp(prm[2], NROW-1); t = clamp(prm[0], NROW-1);
					if (l > r) begin s = l; l = r; r = s; end
					if (t > b) begin s = t; t = b; b = s; end
					vl = l; vr = r; vt = t; vb = b;
					if (col < l || col > r || row < t || row > b) begin col = vl; row = vt; end
				end
				default: begin
					if (int'(prm[1]) >= vl && int'(prm[1]) <= vr) col = prm[1];
					if (int'(prm[0]) >= vt && int'(prm[0]) <= vb) row = prm[0];
				end
			endcase
		endfunction

		function void feed(logic [7:0] b);
			if (pcnt > 0) begin
				pcnt--;
				prm[pcnt] = b;
				if (pcnt == 0) run_cmd();
				return;
			end
			if (b[7]) return;
			if (b < CH_PRINT_LO) begin
				case (b)
					CH_AS_ON:  as_f = 1;
					CH_AS_OFF: as_f = 0;
					CH_LEFT:   go_left();
					CH_RIGHT:  go_right();
					CH_DOWN:   go_down();
					CH_UP:     go_up();
					CH_CLEAR: begin
						for (int r = vt; r <= vb; r++)
							for (int c = vl; c <= vr; c++) put(r, c, fill);
						col = vl; row = vt;
					end
					CH_CR:       col = vl;
					CH_VDU23:    begin pcmd = CMD_VDU23;    pcnt = NPAR_VDU23;    end
					CH_FULL: begin
						vl = 0; vr = NCOL-1; vt = 0; vb = NROW-1; row = 0; col = 0;
					end
					CH_LITERAL:  begin pcmd = CMD_LITERAL;  pcnt = NPAR_LITERAL;  end
					CH_VIEWPORT: begin pcmd = CMD_VIEWPORT; pcnt = NPAR_VIEWPORT; end
					CH_HOME:     begin col = vl; row = vt; end
					CH_MOVE:     begin pcmd = CMD_MOVE;     pcnt = NPAR_MOVE;     end
					default: ;
				endcase
			end else if (b == CH_DELETE) begin
				go_left();
				put(row, col, fill);
			end else begin
				put(row, col, b);
				go_right();
			end
		endfunction

		// note an accepted command transfer
		function void note_item(logic op, logic [7:0] b, logic [3:0] rr, logic [4:0] cc);
			term_status_t s;
			s.rd = 8'd0;
			if (op == OPC_FEED) feed(b);
			else s.rd = get(rr, cc);
			s.row = row[3:0]; s.col = col[4:0]; s.cur_en = ce_f; s.as_en = as_f;
			s.pend = pcnt[3:0];
			expected_status.push_back(s);
		endfunction

		// check an accepted result transfer against the oldest prediction
		function void check_status(term_status_t got);
			term_status_t e;
			if (expected_status.size() == 0) begin
				$error("result transfer with no prediction waiting");
				failed = 1;
				return;
			end
			e = expected_status.pop_front();
			if (got.rd !== e.rd) begin
				$error("read_data expected %0d actual %0d", e.rd, got.rd); failed = 1;
			end
			if (got.row !== e.row) begin
				$error("cursor_row_out expected %0d actual %0d", e.row, got.row); failed = 1;
			end
			if (got.col !== e.col) begin
				$error("cursor_column_out expected %0d actual %0d", e.col, got.col); failed = 1;
			end
			if (got.cur_en !== e.cur_en) begin
				$error("cursor_on expected %0d actual %0d", e.cur_en, got.cur_en); failed = 1;
			end
			if (got.as_en !== e.as_en) begin
				$error("autoscroll_on expected %0d actual %0d", e.as_en, got.as_en); failed = 1;
			end
			if (got.pend !== e.pend) begin
				$error("params_pending expected %0d actual %0d", e.pend, got.pend); failed = 1;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	bit          calm;
	int          idle_cycles;
	int          sent;
	term_scoreboard tracker;

	ttce_cmd_if cmd_ch ();
	ttce_rsp_if rsp_ch ();

	text_terminal_command_engine_core #(.COLUMNS(NCOL), .ROWS(NROW)) DUT (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch.sink), .rsp(rsp_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// random back-pressure on results; check each result transfer
	always @(posedge clk) begin
		term_status_t got;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got.rd = rsp_ch.read_data;
			got.row = rsp_ch.cursor_row_out;
			got.col = rsp_ch.cursor_column_out;
			got.cur_en = rsp_ch.cursor_on;
			got.as_en = rsp_ch.autoscroll_on;
			got.pend = rsp_ch.params_pending;
			tracker.check_status(got);
		end
		rsp_ch.ready <= calm || ($urandom_range(99) >= 25);
	end

	// stop a hung run
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("text_terminal_command_engine_core: mismatch");
			$finish;
		end
	end

	// one command transfer; valid stays high into the next call
	task automatic send_item(logic op, logic [7:0] b, logic [3:0] rr, logic [4:0] cc);
		while (!calm && $urandom_range(99) < 25) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.opcode      <= op;
		cmd_ch.data_byte   <= b;
		cmd_ch.cell_row    <= rr;
		cmd_ch.cell_column <= cc;
		do @(posedge clk); while (!cmd_ch.ready);
		tracker.note_item(op, b, rr, cc);
		sent++;
	endtask

	task automatic feed_byte(logic [7:0] b);
		send_item(OPC_FEED, b, 4'($urandom), 5'($urandom));
	endtask

	task automatic read_cell(logic [3:0] rr, logic [4:0] cc);
		send_item(OPC_READ, 8'($urandom), rr, cc);
	endtask

	// write the fill character through the register port
	task automatic write_fill(logic [7:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_CLEAR_CHAR;
		pwdata  <= {24'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		tracker.fill = v;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// hold until every prediction has been matched, then let the block settle
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (tracker.expected_status.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// one well-formed command with random content
	task automatic random_command();
		case ($urandom_range(3))
			0: begin
				feed_byte(CH_VDU23);
				feed_byte($urandom_range(3) == 0 ? 8'($urandom) :
					($urandom_range(1) ? SEL_CURSOR : SEL_SCROLL));
				feed_byte($urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(1)));
				feed_byte($urandom_range(4) == 0 ? 8'($urandom) : 8'($urandom_range(5)));
				repeat (6) feed_byte(8'($urandom));
			end
			1: begin
				feed_byte(CH_LITERAL);
				feed_byte(8'($urandom));
			end
			2: begin
				feed_byte(CH_VIEWPORT);
				repeat (4) feed_byte($urandom_range(1) ? 8'($urandom_range(40)) : 8'($urandom));
			end
			default: begin
				feed_byte(CH_MOVE);
				feed_byte(8'($urandom_range(40)));
				feed_byte($urandom_range(7) == 0 ? 8'($urandom) : 8'($urandom_range(20)));
			end
		endcase
	endtask

	task automatic random_item();
		int k;
		k = $urandom_range(99);
		if (k < 30)      feed_byte(8'($urandom_range(32, 126)));
		else if (k < 45) read_cell(4'($urandom), 5'($urandom));
		else if (k < 57) feed_byte(8'($urandom_range(31)));
		else if (k < 62) feed_byte(8'($urandom_range(128, 255)));
		else if (k < 72) feed_byte(CH_DELETE);
		else             random_command();
	endtask

	initial begin
		logic [7:0] fills [3];
		fills = '{8'h00, 8'hFF, 8'($urandom)};
		tracker = new();
		arst_n = 1'b0;
		clk = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		cmd_ch.valid = 1'b0; cmd_ch.opcode = OPC_FEED; cmd_ch.data_byte = '0;
		cmd_ch.cell_row = '0; cmd_ch.cell_column = '0;
		rsp_ch.ready = 1'b0;
		calm = 1'b0; idle_cycles = 0; sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: edges of the fields, each control code and command
		write_fill(fills[0]);
		feed_byte(8'd32); feed_byte(8'd126); feed_byte(CH_DELETE);
		feed_byte(CH_LEFT); feed_byte(CH_UP); feed_byte(CH_AS_OFF); feed_byte(CH_UP);
		feed_byte(CH_DOWN); feed_byte(CH_RIGHT); feed_byte(CH_AS_ON); feed_byte(CH_CR);
		feed_byte(8'd0); feed_byte(8'd255); feed_byte(CH_HOME); feed_byte(CH_FULL);
		feed_byte(CH_LITERAL); feed_byte(8'd255);
		feed_byte(CH_VIEWPORT); feed_byte(8'd200); feed_byte(8'd99);
		feed_byte(8'd2); feed_byte(8'd127);
		feed_byte(CH_MOVE); feed_byte(8'd31); feed_byte(8'd15);
		feed_byte(CH_VDU23); feed_byte(SEL_CURSOR); feed_byte(8'd0);
		repeat (7) feed_byte(8'd0);
		feed_byte(CH_VDU23); feed_byte(SEL_SCROLL); feed_byte(8'd1); feed_byte(8'(SC_DOWN));
		repeat (6) feed_byte(8'($urandom));
		feed_byte(CH_CLEAR);
		read_cell(4'd0, 5'd0); read_cell(4'd15, 5'd31);

		// random phases, each with its own fill character
		for (int ph = 0; ph < 3; ph++) begin
			if (ph > 0) begin
				drain();
				write_fill(fills[ph]);
			end
			while (sent < (N_ITEMS * (ph + 1)) / 3) begin
				calm = (ph == 1) && (sent < N_ITEMS / 3 + 300);
				random_item();
			end
			calm = 1'b0;
		end

		drain();
		if (!tracker.failed)
			$display("text_terminal_command_engine_core: match");
		else
			$display("text_terminal_command_engine_core: mismatch");
		$finish;
	end
endmodule
